// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of the project.
// Standalone: no other file is needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, skipped while reset is asserted.
`define CHM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// A signal holds its value across a stalled cycle of a channel.
`define CHM_ASSERT_STALL(lbl, clk, rstn, vld, rdy, sig, msg) \
  `CHM_ASSERT(lbl, clk, rstn, (vld && !rdy) |=> $stable(sig), msg)

`endif

// ===== rtl/core/chm_pkg.sv =====
// Shared types and codes of the chained hash child map.
// No dependencies.
package chm_pkg;

  localparam int OPCODE_W = 2;
  localparam int KEY_W    = 8;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  typedef logic [OPCODE_W-1:0] opcode_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam opcode_t OP_INSERT  = 2'd0;
  localparam opcode_t OP_REMOVE  = 2'd1;
  localparam opcode_t OP_LOOKUP  = 2'd2;
  localparam opcode_t OP_REPLACE = 2'd3;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_FULL      = 2'd2;

endpackage

// ===== rtl/core/chm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module chm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/chm_bucket_div.sv =====
// Bucket index unit: key mod NUM_BUCKETS by reciprocal multiply, then multiply-back and subtract.
// Two registered steps after start; bucket holds until the next start. Depends on chm_pkg.
module chm_bucket_div #(
  parameter int NUM_BUCKETS = 64
) (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  input  logic                                                  start,
  input  logic [chm_pkg::KEY_W-1:0]                             key,
  output logic                                                  done,
  output logic [((NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1)-1:0] bucket
);

  localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int KW     = chm_pkg::KEY_W;
  localparam int RSH    = 2 * KW;
  localparam int PROD_W = KW + RSH;
  // ceil(2^RSH / N) gives the exact quotient for every key while N <= 2^KW
  localparam logic [PROD_W-1:0] RECIP =
    PROD_W'(((1 << RSH) + NUM_BUCKETS - 1) / NUM_BUCKETS);
  localparam logic [KW:0] DIVISOR = (KW + 1)'(NUM_BUCKETS);

  logic              quo_step_r, quo_step_nxt;
  logic              rem_step_r, rem_step_nxt;
  logic              done_r, done_nxt;
  logic [KW-1:0]     key_r, key_nxt;
  logic [KW-1:0]     quo_r, quo_nxt;
  logic [KW-1:0]     rem_r, rem_nxt;
  logic [PROD_W-1:0] prod;
  logic [KW:0]       back;

  assign prod = PROD_W'(key_r) * RECIP;
  // quotient times divisor never exceeds the key, so KW+1 bits hold it
  assign back = (KW + 1)'(quo_r) * DIVISOR;

  always_comb begin
    quo_step_nxt = 1'b0;
    rem_step_nxt = 1'b0;
    done_nxt     = 1'b0;
    key_nxt      = key_r;
    quo_nxt      = quo_r;
    rem_nxt      = rem_r;
    if (start) begin
      key_nxt      = key;
      quo_step_nxt = 1'b1;
    end else if (quo_step_r) begin
      quo_nxt      = KW'(prod >> RSH);
      rem_step_nxt = 1'b1;
    end else if (rem_step_r) begin
      rem_nxt  = KW'({1'b0, key_r} - back);
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quo_step_r <= 1'b0;
      rem_step_r <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      quo_step_r <= quo_step_nxt;
      rem_step_r <= rem_step_nxt;
      done_r     <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done   = done_r;
  assign bucket = rem_r[BKT_W-1:0];

endmodule

// ===== rtl/core/chained_hash_child_map.sv =====
// Chained hash table, byte key to handle. One transaction at a time; in_ready is high only idle.
// Bucket index: reciprocal remainder unit, then bucket RAM read (S_BKT) and capture (S_BCAP).
// Lookup/remove walk each chain entry: slot RAM read (S_WALK), then key compare (S_WCMP).
// Insert: free-stack read or fresh slot, slot write, tail link if needed; replace = remove + insert.
// A new transaction is taken the cycle after the result is registered into out_*.
// Sync reset clears bucket valid bits, counters and handshake state; no sweep.
module chained_hash_child_map #(
  parameter int NUM_BUCKETS = 64,
  parameter int ENTRIES     = 256,
  parameter int HANDLE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  chm_pkg::opcode_t               in_opcode,
  input  logic [chm_pkg::KEY_W-1:0]      in_key,
  input  logic [chm_pkg::HANDLE_W-1:0]   in_handle,
  output logic                           out_valid,
  input  logic                           out_ready,
  output chm_pkg::status_t               out_status,
  output logic [chm_pkg::HANDLE_W-1:0]   out_found_handle,
  output logic [chm_pkg::COUNT_W-1:0]    out_entry_count
);

  localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PTR_W  = $clog2(ENTRIES + 1);
  localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int KW     = chm_pkg::KEY_W;
  localparam int HW     = chm_pkg::HANDLE_W;
  localparam int CW     = chm_pkg::COUNT_W;
  localparam int KH_W   = KW + HANDLE_BITS;
  localparam logic [PTR_W-1:0] NIL = PTR_W'(ENTRIES);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIV    = 4'd1;
  localparam logic [3:0] S_BKT    = 4'd2;
  localparam logic [3:0] S_BCAP   = 4'd3;
  localparam logic [3:0] S_WALK   = 4'd4;
  localparam logic [3:0] S_WCMP   = 4'd5;
  localparam logic [3:0] S_UNLINK = 4'd6;
  localparam logic [3:0] S_ALLOC  = 4'd7;
  localparam logic [3:0] S_ACAP   = 4'd8;
  localparam logic [3:0] S_INS    = 4'd9;
  localparam logic [3:0] S_LINK   = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  logic [3:0]             state_r, state_nxt;
  chm_pkg::opcode_t       op_r, op_nxt;
  logic [KW-1:0]          key_r, key_nxt;
  logic [HW-1:0]          hdl_r, hdl_nxt;
  logic [PTR_W-1:0]       head_r, head_nxt;
  logic [PTR_W-1:0]       tail_r, tail_nxt;
  logic [PTR_W-1:0]       cur_r, cur_nxt;
  logic [PTR_W-1:0]       prev_r, prev_nxt;
  logic [PTR_W-1:0]       slot_r, slot_nxt;
  logic [PTR_W-1:0]       free_top_r, free_top_nxt;
  logic [PTR_W-1:0]       fresh_r, fresh_nxt;
  logic [PTR_W-1:0]       stored_r, stored_nxt;
  logic [NUM_BUCKETS-1:0] bvalid_r, bvalid_nxt;
  chm_pkg::status_t       status_r, status_nxt;
  logic [HW-1:0]          found_r, found_nxt;
  logic                   out_valid_r, out_valid_nxt;
  chm_pkg::status_t       out_status_r, out_status_nxt;
  logic [HW-1:0]          out_found_r, out_found_nxt;
  logic [CW-1:0]          out_count_r, out_count_nxt;

  logic                   accept;
  logic                   div_done;
  logic [BKT_W-1:0]       div_bucket;

  logic                   bkt_we, bkt_re;
  logic [2*PTR_W-1:0]     bkt_wdata, bkt_rdata;
  logic                   slot_re;
  logic                   kh_we;
  logic [KH_W-1:0]        kh_wdata, kh_rdata;
  logic                   link_we;
  logic [SLOT_W-1:0]      link_waddr;
  logic [PTR_W-1:0]       link_wdata, link_rdata;
  logic                   fs_we, fs_re;
  logic [SLOT_W-1:0]      fs_rdata;
  logic [PTR_W-1:0]       ft_dec;

  logic [KW-1:0]          rd_key;
  logic [HANDLE_BITS-1:0] rd_hdl;
  logic [HANDLE_BITS+HW-1:0] hstore_wide;
  logic [HANDLE_BITS+HW-1:0] found_wide;
  logic [PTR_W+CW-1:0]    count_wide;
  logic [PTR_W-1:0]       bkt_head, bkt_tail;
  logic [PTR_W-1:0]       un_head, un_tail, ins_head;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  chm_bucket_div #(
    .NUM_BUCKETS(NUM_BUCKETS)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept),
    .key    (in_key),
    .done   (div_done),
    .bucket (div_bucket)
  );

  chm_ram #(.WIDTH(2*PTR_W), .DEPTH(NUM_BUCKETS)) u_bkt_ram (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (div_bucket),
    .wdata (bkt_wdata),
    .re    (bkt_re),
    .raddr (div_bucket),
    .rdata (bkt_rdata)
  );

  chm_ram #(.WIDTH(KH_W), .DEPTH(ENTRIES)) u_kh_ram (
    .clk   (clk),
    .we    (kh_we),
    .waddr (slot_r[SLOT_W-1:0]),
    .wdata (kh_wdata),
    .re    (slot_re),
    .raddr (cur_r[SLOT_W-1:0]),
    .rdata (kh_rdata)
  );

  chm_ram #(.WIDTH(PTR_W), .DEPTH(ENTRIES)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (slot_re),
    .raddr (cur_r[SLOT_W-1:0]),
    .rdata (link_rdata)
  );

  chm_ram #(.WIDTH(SLOT_W), .DEPTH(ENTRIES)) u_free_ram (
    .clk   (clk),
    .we    (fs_we),
    .waddr (free_top_r[SLOT_W-1:0]),
    .wdata (cur_r[SLOT_W-1:0]),
    .re    (fs_re),
    .raddr (ft_dec[SLOT_W-1:0]),
    .rdata (fs_rdata)
  );

  assign ft_dec      = free_top_r - 1'b1;
  assign rd_key      = kh_rdata[KH_W-1 -: KW];
  assign rd_hdl      = kh_rdata[HANDLE_BITS-1:0];
  assign hstore_wide = {{HANDLE_BITS{1'b0}}, hdl_r};
  assign found_wide  = {{HW{1'b0}}, rd_hdl};
  assign count_wide  = {{CW{1'b0}}, stored_r};
  assign kh_wdata    = {key_r, hstore_wide[HANDLE_BITS-1:0]};

  // bucket never written reads as an empty chain
  assign bkt_head = bvalid_r[div_bucket] ? bkt_rdata[2*PTR_W-1:PTR_W] : NIL;
  assign bkt_tail = bvalid_r[div_bucket] ? bkt_rdata[PTR_W-1:0] : NIL;

  assign un_head  = (prev_r == NIL) ? link_rdata : head_r;
  assign un_tail  = (tail_r == cur_r) ? prev_r : tail_r;
  assign ins_head = (head_r == NIL) ? slot_r : head_r;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    hdl_nxt        = hdl_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    slot_nxt       = slot_r;
    free_top_nxt   = free_top_r;
    fresh_nxt      = fresh_r;
    stored_nxt     = stored_r;
    bvalid_nxt     = bvalid_r;
    status_nxt     = status_r;
    found_nxt      = found_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;

    bkt_we     = 1'b0;
    bkt_re     = 1'b0;
    bkt_wdata  = {head_r, tail_r};
    slot_re    = 1'b0;
    kh_we      = 1'b0;
    link_we    = 1'b0;
    link_waddr = slot_r[SLOT_W-1:0];
    link_wdata = NIL;
    fs_we      = 1'b0;
    fs_re      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt     = in_opcode;
          key_nxt    = in_key;
          hdl_nxt    = in_handle;
          status_nxt = chm_pkg::ST_OK;
          found_nxt  = '0;
          state_nxt  = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_BKT;
        end
      end
      S_BKT: begin
        bkt_re    = 1'b1;
        state_nxt = S_BCAP;
      end
      S_BCAP: begin
        head_nxt  = bkt_head;
        tail_nxt  = bkt_tail;
        cur_nxt   = bkt_head;
        prev_nxt  = NIL;
        state_nxt = (op_r == chm_pkg::OP_INSERT) ? S_ALLOC : S_WALK;
      end
      S_WALK: begin
        if (cur_r == NIL) begin
          status_nxt = chm_pkg::ST_NOT_FOUND;
          state_nxt  = S_DONE;
        end else begin
          slot_re   = 1'b1;
          state_nxt = S_WCMP;
        end
      end
      S_WCMP: begin
        if (rd_key == key_r) begin
          if (op_r == chm_pkg::OP_LOOKUP) begin
            found_nxt = found_wide[HW-1:0];
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_UNLINK;
          end
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = link_rdata;
          state_nxt = S_WALK;
        end
      end
      S_UNLINK: begin
        // link_rdata still holds the successor of the matched slot
        if (prev_r != NIL) begin
          link_we    = 1'b1;
          link_waddr = prev_r[SLOT_W-1:0];
          link_wdata = link_rdata;
        end
        bkt_we                 = 1'b1;
        bkt_wdata              = {un_head, un_tail};
        bvalid_nxt[div_bucket] = 1'b1;
        head_nxt               = un_head;
        tail_nxt               = un_tail;
        fs_we                  = 1'b1;
        free_top_nxt           = free_top_r + 1'b1;
        stored_nxt             = stored_r - 1'b1;
        state_nxt = (op_r == chm_pkg::OP_REPLACE) ? S_ALLOC : S_DONE;
      end
      S_ALLOC: begin
        if (free_top_r != '0) begin
          fs_re        = 1'b1;
          free_top_nxt = ft_dec;
          state_nxt    = S_ACAP;
        end else if (fresh_r != NIL) begin
          slot_nxt  = fresh_r;
          fresh_nxt = fresh_r + 1'b1;
          state_nxt = S_INS;
        end else begin
          status_nxt = chm_pkg::ST_FULL;
          state_nxt  = S_DONE;
        end
      end
      S_ACAP: begin
        slot_nxt  = PTR_W'(fs_rdata);
        state_nxt = S_INS;
      end
      S_INS: begin
        kh_we                  = 1'b1;
        link_we                = 1'b1;
        bkt_we                 = 1'b1;
        bkt_wdata              = {ins_head, slot_r};
        bvalid_nxt[div_bucket] = 1'b1;
        stored_nxt             = stored_r + 1'b1;
        state_nxt = (head_r == NIL) ? S_DONE : S_LINK;
      end
      S_LINK: begin
        link_we    = 1'b1;
        link_waddr = tail_r[SLOT_W-1:0];
        link_wdata = slot_r;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_found_nxt  = found_r;
          out_count_nxt  = count_wide[CW-1:0];
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      free_top_r  <= '0;
      fresh_r     <= '0;
      stored_r    <= '0;
      bvalid_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      free_top_r  <= free_top_nxt;
      fresh_r     <= fresh_nxt;
      stored_r    <= stored_nxt;
      bvalid_r    <= bvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    hdl_r        <= hdl_nxt;
    head_r       <= head_nxt;
    tail_r       <= tail_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    slot_r       <= slot_nxt;
    status_r     <= status_nxt;
    found_r      <= found_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_found_handle = out_found_r;
  assign out_entry_count  = out_count_r;

endmodule

// ===== rtl/core/chm_checker.sv =====
// Port-level checks of chained_hash_child_map, attached by bind.
// Depends on chm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module chm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input chm_pkg::status_t             out_status,
  input logic [chm_pkg::HANDLE_W-1:0] out_found_handle,
  input logic [chm_pkg::COUNT_W-1:0]  out_entry_count
);

  `CHM_ASSERT_STALL(a_out_valid_hold, clk, rst_n, out_valid, out_ready, out_valid, "out_valid dropped while stalled")
  `CHM_ASSERT_STALL(a_out_payload_hold, clk, rst_n, out_valid, out_ready, ({out_status, out_found_handle, out_entry_count}), "result changed while stalled")
  `CHM_ASSERT(a_busy_after_accept, clk, rst_n, (in_valid && in_ready) |=> !in_ready, "new transaction taken while busy")
  `CHM_ASSERT(a_found_zero_on_fail, clk, rst_n, (out_valid && (out_status != chm_pkg::ST_OK)) |-> (out_found_handle == '0), "found handle set on failed request")

endmodule

bind chained_hash_child_map chm_checker u_chm_checker (.*);
